[design/bca_pkg.sv]
// Shared constants, field widths and helper function of the block chain allocator.
package bca_pkg;

  localparam int NUM_BLOCKS_DEF = 256;
  localparam int FREE_WORD_W    = 64;
  localparam int FREE_BIT_W     = 6;

  localparam int MODE_W   = 3;
  localparam int BLOCK_W  = 8;
  localparam int STATUS_W = 2;
  localparam int CLEN_W   = 9;

  localparam logic [MODE_W-1:0] MODE_ALLOC   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_EXTEND  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_NEXT    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_COUNT   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFREE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONEXT = 2'd2;

  // Index of the lowest set bit; zero when no bit is set.
  function automatic logic [FREE_BIT_W-1:0] lowest_set(input logic [FREE_WORD_W-1:0] v);
    logic [FREE_BIT_W-1:0] idx;
    idx = '0;
    for (int i = FREE_WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = FREE_BIT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

[design/bca_if.sv]
// Request and result channel interfaces of the block chain allocator.
interface bca_in_if import bca_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [BLOCK_W-1:0] block;

  modport source (output valid, output mode, output block, input ready);
  modport sink (input valid, input mode, input block, output ready);
endinterface

interface bca_out_if import bca_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [BLOCK_W-1:0]  block_out;
  logic [STATUS_W-1:0] status;
  logic [CLEN_W-1:0]   chain_length;

  modport source (output valid, output block_out, output status, output chain_length,
                  input ready);
  modport sink (input valid, input block_out, input status, input chain_length,
                output ready);
endinterface

[design/block_chain_allocator.sv]
// Top level of the block chain allocator: link table, free bitmap and request sequencer.
//
// The link table holds one entry per block (a link, free, or end of chain) and
// a second memory holds a free bitmap in 64-bit words, with one flag per word
// in registers, so the lowest free block is found by reading a single word.
// After reset a clearing pass marks every block free; no request is accepted
// until it ends. Each request is one transaction and gives one result
// transaction. Next and extend read the entry of the start block; extend at
// the end of a chain then allocates a block and links it on. Allocate reads
// the lowest free word and takes its lowest free block. Count and release walk
// the chain, reading every block of it and also the free entry that stops it;
// unused modes and out-of-range starts go straight to the result. A new request
// is taken in the cycle after the previous result is registered, while that
// result may still wait on the output.
module block_chain_allocator import bca_pkg::*; #(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  bca_in_if.sink     in_ch,
  bca_out_if.source  out_ch
);

  localparam int IDX_W      = $clog2(NUM_BLOCKS);
  localparam int LINK_W     = $clog2(NUM_BLOCKS + 2);
  localparam int LEN_W      = $clog2(NUM_BLOCKS + 1);
  localparam int NWORDS     = (NUM_BLOCKS + FREE_WORD_W - 1) / FREE_WORD_W;
  localparam int WORD_IDX_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int LAST_BITS  = NUM_BLOCKS - (NWORDS - 1) * FREE_WORD_W;
  localparam logic [FREE_WORD_W-1:0] LAST_MASK =
    (LAST_BITS == FREE_WORD_W) ? {FREE_WORD_W{1'b1}}
                               : ((FREE_WORD_W'(1) << LAST_BITS) - FREE_WORD_W'(1));
  localparam logic [LINK_W-1:0] LINK_FREE = LINK_W'(NUM_BLOCKS);
  localparam logic [LINK_W-1:0] LINK_END  = LINK_W'(NUM_BLOCKS + 1);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_RD,
    S_DATA,
    S_ALLOC_RD,
    S_ALLOC_PE,
    S_EXT_LINK,
    S_RESP
  } state_t;

  state_t                state_r, state_nxt;
  logic [IDX_W-1:0]      init_cnt_r, init_cnt_nxt;
  logic [MODE_W-1:0]     mode_r, mode_nxt;
  logic [IDX_W-1:0]      cur_r, cur_nxt;
  logic [WORD_IDX_W-1:0] wi_r, wi_nxt;
  logic [IDX_W-1:0]      f_r, f_nxt;
  logic [LEN_W-1:0]      cnt_r, cnt_nxt;
  logic [NWORDS-1:0]     summary_r, summary_nxt;
  logic [BLOCK_W-1:0]    res_blk_r, res_blk_nxt;
  logic [STATUS_W-1:0]   res_status_r, res_status_nxt;
  logic [CLEN_W-1:0]     res_len_r, res_len_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [BLOCK_W-1:0]    out_blk_r, out_blk_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [CLEN_W-1:0]     out_len_r, out_len_nxt;

  logic                   link_we;
  logic [IDX_W-1:0]       link_waddr, link_raddr;
  logic [LINK_W-1:0]      link_wdata, link_rdata;
  logic                   bm_we;
  logic [WORD_IDX_W-1:0]  bm_waddr, bm_raddr;
  logic [FREE_WORD_W-1:0] bm_wdata, bm_rdata;

  logic [WORD_IDX_W-1:0]  cur_word, sum_word;
  logic [FREE_BIT_W-1:0]  cur_bit, alloc_bit;
  logic [IDX_W-1:0]       alloc_blk, link_next;
  logic [LEN_W-1:0]       cnt_inc;
  logic                   in_range, e_free, e_end, e_link;

  bca_ram #(.WIDTH(LINK_W), .DEPTH(NUM_BLOCKS), .AW(IDX_W)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  bca_ram #(.WIDTH(FREE_WORD_W), .DEPTH(NWORDS), .AW(WORD_IDX_W)) u_free_ram (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  assign cur_word  = WORD_IDX_W'(32'(cur_r) >> FREE_BIT_W);
  assign cur_bit   = FREE_BIT_W'(cur_r);
  assign sum_word  = WORD_IDX_W'(lowest_set(FREE_WORD_W'(summary_r)));
  assign alloc_bit = lowest_set(bm_rdata);
  assign alloc_blk = IDX_W'({wi_r, alloc_bit});
  assign link_next = IDX_W'(link_rdata);
  assign cnt_inc   = cnt_r + LEN_W'(1);
  assign in_range  = 32'(in_ch.block) < NUM_BLOCKS;
  assign e_free    = (link_rdata == LINK_FREE);
  assign e_end     = (link_rdata == LINK_END);
  assign e_link    = (link_rdata < LINK_FREE);

  always_comb begin
    state_nxt      = state_r;
    init_cnt_nxt   = init_cnt_r;
    mode_nxt       = mode_r;
    cur_nxt        = cur_r;
    wi_nxt         = wi_r;
    f_nxt          = f_r;
    cnt_nxt        = cnt_r;
    summary_nxt    = summary_r;
    res_blk_nxt    = res_blk_r;
    res_status_nxt = res_status_r;
    res_len_nxt    = res_len_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_blk_nxt    = out_blk_r;
    out_status_nxt = out_status_r;
    out_len_nxt    = out_len_r;
    link_we        = 1'b0;
    link_waddr     = cur_r;
    link_wdata     = LINK_FREE;
    link_raddr     = cur_r;
    bm_we          = 1'b0;
    bm_waddr       = cur_word;
    bm_wdata       = bm_rdata | (FREE_WORD_W'(1) << cur_bit);
    bm_raddr       = cur_word;

    unique case (state_r)
      S_INIT: begin
        link_we    = 1'b1;
        link_waddr = init_cnt_r;
        link_wdata = LINK_FREE;
        if (32'(init_cnt_r) < NWORDS) begin
          bm_we    = 1'b1;
          bm_waddr = WORD_IDX_W'(init_cnt_r);
          bm_wdata = (32'(init_cnt_r) == NWORDS - 1) ? LAST_MASK : {FREE_WORD_W{1'b1}};
        end
        if (init_cnt_r == IDX_W'(NUM_BLOCKS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          init_cnt_nxt = init_cnt_r + IDX_W'(1);
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          mode_nxt       = in_ch.mode;
          cur_nxt        = IDX_W'(in_ch.block);
          cnt_nxt        = '0;
          res_blk_nxt    = '0;
          res_status_nxt = ST_OK;
          res_len_nxt    = '0;
          unique case (in_ch.mode)
            MODE_ALLOC: state_nxt = S_ALLOC_RD;
            MODE_EXTEND, MODE_NEXT, MODE_COUNT: begin
              if (in_range) begin
                state_nxt = S_RD;
              end else begin
                res_status_nxt = ST_NONEXT;
                state_nxt      = S_RESP;
              end
            end
            MODE_RELEASE: state_nxt = in_range ? S_RD : S_RESP;
            default: state_nxt = S_RESP;
          endcase
        end
      end
      S_RD: begin
        state_nxt = S_DATA;
      end
      S_DATA: begin
        unique case (mode_r)
          MODE_EXTEND, MODE_NEXT: begin
            if (e_link) begin
              res_blk_nxt = BLOCK_W'(link_rdata);
              state_nxt   = S_RESP;
            end else if (e_end && mode_r == MODE_EXTEND) begin
              state_nxt = S_ALLOC_RD;
            end else begin
              res_status_nxt = ST_NONEXT;
              state_nxt      = S_RESP;
            end
          end
          MODE_COUNT: begin
            if (e_free) begin
              if (cnt_r == '0) begin
                res_status_nxt = ST_NONEXT;
              end
              res_len_nxt = CLEN_W'(cnt_r);
              state_nxt   = S_RESP;
            end else begin
              cnt_nxt = cnt_inc;
              if (e_end || cnt_inc == LEN_W'(NUM_BLOCKS)) begin
                res_len_nxt = CLEN_W'(cnt_inc);
                state_nxt   = S_RESP;
              end else begin
                cur_nxt    = link_next;
                link_raddr = link_next;
              end
            end
          end
          MODE_RELEASE: begin
            if (e_free) begin
              state_nxt = S_RESP;
            end else begin
              link_we               = 1'b1;
              link_wdata            = LINK_FREE;
              bm_we                 = 1'b1;
              summary_nxt[cur_word] = 1'b1;
              cnt_nxt               = cnt_inc;
              if (e_end || cnt_inc == LEN_W'(NUM_BLOCKS)) begin
                state_nxt = S_RESP;
              end else begin
                cur_nxt   = link_next;
                state_nxt = S_RD;
              end
            end
          end
          default: state_nxt = S_RESP;
        endcase
      end
      S_ALLOC_RD: begin
        if (summary_r == '0) begin
          res_status_nxt = ST_NOFREE;
          state_nxt      = S_RESP;
        end else begin
          wi_nxt    = sum_word;
          bm_raddr  = sum_word;
          state_nxt = S_ALLOC_PE;
        end
      end
      S_ALLOC_PE: begin
        bm_we             = 1'b1;
        bm_waddr          = wi_r;
        bm_wdata          = bm_rdata & ~(FREE_WORD_W'(1) << alloc_bit);
        summary_nxt[wi_r] = |bm_wdata;
        link_we           = 1'b1;
        link_waddr        = alloc_blk;
        link_wdata        = LINK_END;
        f_nxt             = alloc_blk;
        res_blk_nxt       = BLOCK_W'(alloc_blk);
        state_nxt         = (mode_r == MODE_EXTEND) ? S_EXT_LINK : S_RESP;
      end
      S_EXT_LINK: begin
        link_we    = 1'b1;
        link_waddr = cur_r;
        link_wdata = LINK_W'(f_r);
        state_nxt  = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_blk_nxt    = res_blk_r;
          out_status_nxt = res_status_r;
          out_len_nxt    = res_len_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      init_cnt_r  <= '0;
      summary_r   <= '1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_cnt_r  <= init_cnt_nxt;
      summary_r   <= summary_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r       <= mode_nxt;
    cur_r        <= cur_nxt;
    wi_r         <= wi_nxt;
    f_r          <= f_nxt;
    cnt_r        <= cnt_nxt;
    res_blk_r    <= res_blk_nxt;
    res_status_r <= res_status_nxt;
    res_len_r    <= res_len_nxt;
    out_blk_r    <= out_blk_nxt;
    out_status_r <= out_status_nxt;
    out_len_r    <= out_len_nxt;
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.block_out    = out_blk_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.chain_length = out_len_r;

  // The word flag said this word holds a free block, so the word read must agree.
  a_alloc_word_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ALLOC_PE |-> bm_rdata != '0)
    else $error("free word flag set for a word with no free block");

  // A block whose link entry is in use must not be marked free in the bitmap.
  a_bitmap_matches_link: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DATA && mode_r == MODE_RELEASE && !e_free |-> !bm_rdata[cur_bit])
    else $error("allocated block is marked free in the bitmap");

  // No table write happens while the block waits for a request.
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !link_we && !bm_we)
    else $error("table written while idle");

  // Chain walks never exceed the table size.
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DATA |-> 32'(cnt_r) < NUM_BLOCKS)
    else $error("chain walk ran past the table size");

  // Every accepted request takes the block out of idle, so it produces a result before the next one is accepted.
  a_result_before_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r != S_IDLE)
    else $error("request accepted without producing a result");

endmodule

[design/bca_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module bca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[verif/bca_checker.sv]
// Checker of the block chain allocator: watches both channels, predicts each result and compares.
module bca_checker import bca_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  bca_in_if         in_mon,
  bca_out_if        out_mon,
  output int        errors,
  output int        pending
);

  localparam int NBLK = NUM_BLOCKS_DEF;
  localparam logic [CLEN_W-1:0] ENTRY_FREE = CLEN_W'(NBLK);
  localparam logic [CLEN_W-1:0] ENTRY_END  = CLEN_W'(NBLK + 1);

  typedef struct packed {
    logic [BLOCK_W-1:0]  block_out;
    logic [STATUS_W-1:0] status;
    logic [CLEN_W-1:0]   chain_length;
  } alloc_result_t;

  logic [CLEN_W-1:0] links [NBLK];
  alloc_result_t     expected_q [$];
  int                n_expected;
  int                n_checked;

  assign pending = n_expected - n_checked;

  initial begin
    errors     = 0;
    n_expected = 0;
    n_checked  = 0;
  end

  task automatic report(input string msg);
    errors++;
    if (errors <= 40) begin
      $display("checker: %s", msg);
    end
  endtask

  function automatic int lowest_free_block();
    for (int i = 0; i < NBLK; i++) begin
      if (links[i] == ENTRY_FREE) begin
        return i;
      end
    end
    return NBLK;
  endfunction

  function automatic alloc_result_t apply_request(input logic [MODE_W-1:0] mode,
                                                  input logic [BLOCK_W-1:0] blk);
    alloc_result_t     r;
    int                f;
    int                cur;
    logic [CLEN_W-1:0] e;
    r = '0;
    case (mode)
      MODE_ALLOC: begin
        f = lowest_free_block();
        if (f >= NBLK) begin
          r.status = ST_NOFREE;
        end else begin
          links[f] = ENTRY_END;
          r.block_out = BLOCK_W'(f);
        end
      end
      MODE_EXTEND, MODE_NEXT: begin
        e = links[blk];
        if (e < ENTRY_FREE) begin
          r.block_out = e[BLOCK_W-1:0];
        end else if (e == ENTRY_END && mode == MODE_EXTEND) begin
          f = lowest_free_block();
          if (f >= NBLK) begin
            r.status = ST_NOFREE;
          end else begin
            links[f] = ENTRY_END;
            links[blk] = CLEN_W'(f);
            r.block_out = BLOCK_W'(f);
          end
        end else begin
          r.status = ST_NONEXT;
        end
      end
      MODE_RELEASE: begin
        cur = int'(blk);
        for (int s = 0; s < NBLK && cur < NBLK; s++) begin
          e = links[cur];
          if (e == ENTRY_FREE) break;
          links[cur] = ENTRY_FREE;
          if (e == ENTRY_END) break;
          cur = int'(e);
        end
      end
      MODE_COUNT: begin
        if (links[blk] == ENTRY_FREE) begin
          r.status = ST_NONEXT;
        end else begin
          cur = int'(blk);
          for (int s = 0; s < NBLK && cur < NBLK; s++) begin
            e = links[cur];
            if (e == ENTRY_FREE) break;
            r.chain_length = r.chain_length + CLEN_W'(1);
            if (e == ENTRY_END) break;
            cur = int'(e);
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < NBLK; i++) begin
        links[i] = ENTRY_FREE;
      end
      expected_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          report("result transaction arrived with no request outstanding");
        end else begin
          want = expected_q.pop_front();
          n_checked++;
          if (out_mon.block_out !== want.block_out) begin
            report($sformatf("result %0d: block_out %0d, expected %0d",
                             n_checked, out_mon.block_out, want.block_out));
          end
          if (out_mon.status !== want.status) begin
            report($sformatf("result %0d: status %0d, expected %0d",
                             n_checked, out_mon.status, want.status));
          end
          if (out_mon.chain_length !== want.chain_length) begin
            report($sformatf("result %0d: chain_length %0d, expected %0d",
                             n_checked, out_mon.chain_length, want.chain_length));
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_q.push_back(apply_request(in_mon.mode, in_mon.block));
        n_expected++;
      end
    end
  end

endmodule

[verif/testbench.sv]
// Top of the block chain allocator testbench: clock, reset, request and result traffic, verdict.
module testbench;
  import bca_pkg::*;

  localparam int NBLK = NUM_BLOCKS_DEF;
  localparam int TARGET_REQUESTS = 1650;
  localparam logic [MODE_W-1:0] MODE_TOP = '1;

  logic clk;
  logic rst_n;
  int   chk_errors;
  int   chk_pending;

  bca_in_if  in_ch();
  bca_out_if out_ch();

  block_chain_allocator u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  bca_checker u_chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_mon  (in_ch),
    .out_mon (out_ch),
    .errors  (chk_errors),
    .pending (chk_pending)
  );

  int                  sent_total;
  int                  got_total;
  int                  chains_built;
  int                  longest_chain;
  bit                  idle_on;
  logic [BLOCK_W-1:0]  last_blk;
  logic [STATUS_W-1:0] last_st;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("testbench: errors");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_total <= got_total + 1;
      last_blk  <= out_ch.block_out;
      last_st   <= out_ch.status;
    end
  end

  // Result side: short random stalls, occasional long ones, and stall-free stretches.
  initial begin
    int stall_left;
    int phase_left;
    bit no_stall;
    out_ch.ready = 1'b0;
    stall_left = 0;
    phase_left = 0;
    no_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (phase_left == 0) begin
        phase_left = $urandom_range(50, 400);
        no_stall = ($urandom_range(0, 3) == 0);
      end
      phase_left--;
      if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else if (no_stall) begin
        out_ch.ready = 1'b1;
      end else if ($urandom_range(0, 99) < 2) begin
        out_ch.ready = 1'b0;
        stall_left = $urandom_range(10, 50);
      end else begin
        out_ch.ready = ($urandom_range(0, 99) >= 30);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (!idle_on) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  task automatic send_req(input logic [MODE_W-1:0] m, input logic [BLOCK_W-1:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.mode  = m;
    in_ch.block = b;
    in_ch.valid = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    in_ch.valid = 1'b0;
    sent_total++;
  endtask

  task automatic await_result();
    while (got_total != sent_total) @(negedge clk);
  endtask

  function automatic logic [BLOCK_W-1:0] pick_block();
    if ($urandom_range(0, 9) < 7) begin
      return BLOCK_W'($urandom_range(0, 47));
    end
    return BLOCK_W'($urandom_range(0, NBLK - 1));
  endfunction

  // Allocates a head and extends its tail one block at a time, then works on the chain.
  task automatic build_chain(input int max_len);
    logic [BLOCK_W-1:0] head;
    logic [BLOCK_W-1:0] tail;
    int                 len;
    send_req(MODE_ALLOC, BLOCK_W'($urandom_range(0, NBLK - 1)));
    await_result();
    if (last_st == ST_OK) begin
      head = last_blk;
      tail = head;
      len = 1;
      while (len < max_len) begin
        send_req(MODE_EXTEND, tail);
        await_result();
        if (last_st != ST_OK) break;
        tail = last_blk;
        len++;
      end
      chains_built++;
      if (len > longest_chain) begin
        longest_chain = len;
      end
      send_req(MODE_COUNT, head);
      send_req(MODE_NEXT, head);
      send_req(MODE_EXTEND, head);
      send_req(MODE_NEXT, tail);
      case ($urandom_range(0, 3))
        0, 1: send_req(MODE_RELEASE, head);
        2: send_req(MODE_RELEASE, tail);
        default: begin
        end
      endcase
    end
  endtask

  task automatic noise_batch();
    int                 n;
    logic [MODE_W-1:0]  m;
    n = $urandom_range(4, 12);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 12) begin
        m = MODE_W'($urandom_range(int'(MODE_COUNT) + 1, int'(MODE_TOP)));
      end else begin
        m = MODE_W'($urandom_range(int'(MODE_ALLOC), int'(MODE_COUNT)));
      end
      send_req(m, pick_block());
    end
  endtask

  // Empties the table, builds one chain over every block, and probes the full table.
  task automatic fill_table();
    logic [BLOCK_W-1:0] head;
    logic [BLOCK_W-1:0] tail;
    int                 len;
    for (int i = 0; i < NBLK; i++) begin
      send_req(MODE_RELEASE, BLOCK_W'(i));
    end
    send_req(MODE_ALLOC, '0);
    await_result();
    head = last_blk;
    tail = head;
    len = 1;
    while (len <= NBLK) begin
      send_req(MODE_EXTEND, tail);
      await_result();
      if (last_st != ST_OK) break;
      tail = last_blk;
      len++;
    end
    if (len > longest_chain) begin
      longest_chain = len;
    end
    send_req(MODE_COUNT, head);
    send_req(MODE_ALLOC, '1);
    send_req(MODE_EXTEND, tail);
    send_req(MODE_NEXT, tail);
    send_req(MODE_RELEASE, head);
    send_req(MODE_COUNT, head);
  endtask

  initial begin
    bit filled;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_ALLOC;
    in_ch.block = '0;
    sent_total = 0;
    got_total = 0;
    chains_built = 0;
    longest_chain = 0;
    last_blk = '0;
    last_st = ST_OK;
    idle_on = 1'b0;
    filled = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // Directed requests: allocation, extension, dangling links, free starts, unused modes.
    send_req(MODE_ALLOC, '1);
    send_req(MODE_ALLOC, '0);
    send_req(MODE_EXTEND, 8'd0);
    send_req(MODE_EXTEND, 8'd0);
    send_req(MODE_NEXT, 8'd0);
    send_req(MODE_NEXT, 8'd2);
    send_req(MODE_NEXT, 8'd255);
    send_req(MODE_EXTEND, 8'd255);
    send_req(MODE_COUNT, 8'd0);
    send_req(MODE_COUNT, 8'd255);
    send_req(MODE_RELEASE, 8'd1);
    send_req(MODE_EXTEND, 8'd2);
    send_req(MODE_COUNT, 8'd0);
    send_req(MODE_RELEASE, 8'd2);
    send_req(MODE_NEXT, 8'd0);
    send_req(MODE_EXTEND, 8'd0);
    send_req(MODE_COUNT, 8'd0);
    send_req(MODE_RELEASE, 8'd255);
    send_req(MODE_COUNT + 3'd1, 8'd255);
    send_req(MODE_COUNT + 3'd2, 8'hAA);
    send_req(MODE_TOP, 8'h55);
    send_req(MODE_RELEASE, 8'd0);
    send_req(MODE_COUNT, 8'd0);

    while (sent_total < TARGET_REQUESTS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if (!filled && sent_total >= 700) begin
        fill_table();
        filled = 1'b1;
      end else if ($urandom_range(0, 99) < 50) begin
        build_chain(($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 8));
      end else begin
        noise_batch();
      end
    end

    while (chk_pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    $display("testbench: %0d requests, %0d results; %0d chains built, longest %0d blocks",
             sent_total, got_total, chains_built, longest_chain);
    if (chk_errors == 0 && chk_pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
